### rtl/core/positional_list_store_core_defines.svh
// assertion helpers for the positional list store
`ifndef POSITIONAL_LIST_STORE_CORE_DEFINES_SVH
`define POSITIONAL_LIST_STORE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PLSC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("plsc check failed");

// next-cycle implication, checked outside reset
`define PLSC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("plsc check failed");

`endif

### rtl/core/plsc_pkg.sv
package plsc_pkg;

	// default list depth
	localparam int PLSC_DEPTH = 16;

	// field widths
	localparam int CMD_W = 3;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_HEAD = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_TAIL = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_AT   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd6;

	// status codes
	localparam logic [ST_W-1:0] ST_OK     = 2'd0;
	localparam logic [ST_W-1:0] ST_BADIDX = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} request_t;

	typedef struct packed {
		logic [ST_W-1:0]         status;
		logic signed [VAL_W-1:0] entry_value;
		logic [CNT_W-1:0]        entry_count;
		logic                    last;
	} result_t;

endpackage

### rtl/core/positional_list_store_core.sv
// positional list store: edits finish straight from idle when no entry moves, else
// they stay busy while n entries are shifted, one per cycle, n being the number moved
// a dump reads the entries through the registered memory and gives one result per cycle
// results leave a register; the receiver cannot stall
// reset clears the count and the sequencer; entry contents are left as they are
`include "positional_list_store_core_defines.svh"

module positional_list_store_core
	import plsc_pkg::*;
#(
	parameter int DEPTH = PLSC_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     done,
	output result_t  result
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SHIFT = 2'd1;
	localparam logic [1:0] S_DUMP  = 2'd2;

	logic [1:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [AW-1:0]       rd_addr_q;
	logic [AW-1:0]       wr_addr_q;
	logic [CW-1:0]       rd_left_q;
	logic                pend_s1;
	logic                up_q;
	logic                ins_q;
	logic [AW-1:0]       pos_q;
	logic [VAL_W-1:0]    val_q;
	logic                done_q;
	result_t             result_q;

	logic [VAL_W-1:0]    mem [DEPTH];
	logic [VAL_W-1:0]    rdata_s1;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [VAL_W-1:0]    mem_wdata;
	logic [AW-1:0]       mem_raddr;

	logic                accept;
	logic                c_ins;
	logic                c_del;
	logic [PW-1:0]       c_pos;
	logic [PW-1:0]       c_cnt;
	logic [ST_W-1:0]     c_status;
	logic [PW-1:0]       c_shift;
	logic                full;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign done   = done_q;
	assign result = result_q;
	assign full   = (count_q == CW'(DEPTH));
	assign c_cnt  = PW'(count_q);

	// request decode: edit position, status and number of entries to move
	always_comb begin
		c_ins    = 1'b0;
		c_del    = 1'b0;
		c_pos    = '0;
		c_status = ST_OK;
		c_shift  = '0;
		case (request.command)
			CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
				c_ins = 1'b1;
				if (request.command == CMD_INS_TAIL) begin
					c_pos = c_cnt;
				end else if (request.command == CMD_INS_AT) begin
					c_pos = PW'(request.position);
				end
				if (c_pos > c_cnt) begin
					c_status = ST_BADIDX;
				end else if (full) begin
					c_status = ST_FULL;
				end
				c_shift = c_cnt - c_pos;
			end
			CMD_DEL_HEAD, CMD_DEL_TAIL, CMD_DEL_AT: begin
				c_del = 1'b1;
				if (request.command == CMD_DEL_TAIL) begin
					c_pos = c_cnt - PW'(1);
				end else if (request.command == CMD_DEL_AT) begin
					c_pos = PW'(request.position);
				end
				if (request.command == CMD_DEL_AT) begin
					if (c_pos >= c_cnt) begin
						c_status = ST_BADIDX;
					end
				end else if (count_q == '0) begin
					c_status = ST_EMPTY;
				end
				c_shift = c_cnt - PW'(1) - c_pos;
			end
			default: begin
			end
		endcase
	end

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = rd_addr_q;
		case (state_q)
			S_IDLE: begin
				if (accept && c_ins && c_status == ST_OK && c_shift == '0) begin
					mem_we    = 1'b1;
					mem_waddr = c_pos[AW-1:0];
					mem_wdata = request.value;
				end
			end
			S_SHIFT: begin
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = wr_addr_q;
					mem_wdata = rdata_s1;
				end else if (rd_left_q == '0 && ins_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q;
					mem_wdata = val_q;
				end
			end
			default: begin
			end
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[mem_raddr];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			rd_left_q <= '0;
			pend_s1   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					if (accept) begin
						if (c_ins || c_del) begin
							if (c_status != ST_OK || c_shift == '0) begin
								done_q <= 1'b1;
								if (c_status == ST_OK) begin
									count_q <= c_ins ? count_q + CW'(1) : count_q - CW'(1);
								end
							end else begin
								state_q   <= S_SHIFT;
								rd_left_q <= c_shift[CW-1:0];
							end
						end else if (request.command == CMD_DUMP) begin
							if (count_q == '0) begin
								done_q <= 1'b1;
							end else begin
								state_q   <= S_DUMP;
								rd_left_q <= count_q;
							end
						end
					end
				end
				S_SHIFT, S_DUMP: begin
					if (rd_left_q != '0) begin
						rd_left_q <= rd_left_q - CW'(1);
						pend_s1   <= 1'b1;
					end else begin
						pend_s1 <= 1'b0;
					end
					if (state_q == S_DUMP && pend_s1) begin
						done_q <= 1'b1;
					end
					if (rd_left_q == '0 && !pend_s1) begin
						state_q <= S_IDLE;
						if (state_q == S_SHIFT) begin
							done_q  <= 1'b1;
							count_q <= ins_q ? count_q + CW'(1) : count_q - CW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk addresses and request payload
	always_ff @(posedge clk) begin
		if (accept) begin
			ins_q <= c_ins;
			pos_q <= c_pos[AW-1:0];
			val_q <= request.value;
			if (c_ins) begin
				up_q      <= 1'b0;
				rd_addr_q <= AW'(count_q - CW'(1));
				wr_addr_q <= AW'(count_q);
			end else if (c_del) begin
				up_q      <= 1'b1;
				rd_addr_q <= AW'(c_pos + PW'(1));
				wr_addr_q <= c_pos[AW-1:0];
			end else begin
				up_q      <= 1'b1;
				rd_addr_q <= '0;
				wr_addr_q <= '0;
			end
		end else if (busy) begin
			if (rd_left_q != '0) begin
				rd_addr_q <= up_q ? rd_addr_q + AW'(1) : rd_addr_q - AW'(1);
			end
			if (pend_s1) begin
				wr_addr_q <= up_q ? wr_addr_q + AW'(1) : wr_addr_q - AW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			result_q.entry_value <= '0;
			result_q.last        <= 1'b1;
			if (c_ins || c_del) begin
				result_q.status <= c_status;
				if (c_status == ST_OK) begin
					result_q.entry_count <= CNT_W'(c_ins ? count_q + CW'(1)
						: count_q - CW'(1));
				end else begin
					result_q.entry_count <= CNT_W'(count_q);
				end
			end else begin
				result_q.status      <= ST_EMPTY;
				result_q.entry_count <= CNT_W'(count_q);
			end
		end else if (state_q == S_DUMP) begin
			result_q.status      <= ST_OK;
			result_q.entry_value <= rdata_s1;
			result_q.entry_count <= CNT_W'(count_q);
			result_q.last        <= (rd_left_q == '0);
		end else begin
			result_q.status      <= ST_OK;
			result_q.entry_value <= '0;
			result_q.entry_count <= CNT_W'(ins_q ? count_q + CW'(1) : count_q - CW'(1));
			result_q.last        <= 1'b1;
		end
	end

	// checks
	`PLSC_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH))
	`PLSC_ASSERT_NOW(a_full_status, done_q && result_q.status == ST_FULL, full)
	`PLSC_ASSERT_NOW(a_no_result_in_shift, state_q == S_SHIFT, !done_q)
	`PLSC_ASSERT_NOW(a_pend_when_busy, pend_s1, busy)
	`PLSC_ASSERT_NEXT(a_shift_keeps_count, state_q == S_SHIFT && (rd_left_q != '0 || pend_s1),
		count_q == $past(count_q))

endmodule
